/* design/dttm_pkg.sv */
// Shared types and constants for the duration text to milliseconds parser.
`default_nettype none

package dttm_pkg;

	// Parser phase within the current token
	typedef enum logic [2:0] {
		PH_START,
		PH_WS,
		PH_SIGN,
		PH_DIG,
		PH_PENDM,
		PH_STOP
	} phase_t;

	// Unit scale applied to a finished token
	typedef enum logic [2:0] {
		FAC_MS,
		FAC_SEC,
		FAC_MIN,
		FAC_HOUR,
		FAC_DAY
	} factor_t;

	// Token contributions handed from the parse stage to the scale stage
	typedef struct packed {
		factor_t     factor;
		logic [63:0] val_a;
		logic [63:0] val_b;
	} tok_out_t;

	localparam logic [63:0] POS_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_CAP = 64'h8000_0000_0000_0000;
	// Both caps divided by ten; the last digit then decides one less or not
	localparam logic [63:0] MAG_THR = 64'd922337203685477580;
	localparam logic [3:0]  POS_LAST_DIGIT = 4'd7;
	localparam logic [3:0]  NEG_LAST_DIGIT = 4'd8;

	localparam logic [63:0] MS_PER_SEC  = 64'd1000;
	localparam logic [63:0] MS_PER_MIN  = 64'd60000;
	localparam logic [63:0] MS_PER_HOUR = 64'd3600000;
	localparam logic [63:0] MS_PER_DAY  = 64'd86400000;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_CASE  = 8'h20;
	localparam logic [7:0] CH_LO_D  = 8'h64;
	localparam logic [7:0] CH_LO_H  = 8'h68;
	localparam logic [7:0] CH_LO_M  = 8'h6D;
	localparam logic [7:0] CH_LO_S  = 8'h73;

endpackage

`default_nettype wire

/* design/duration_text_to_milliseconds.sv */
// Top level of the duration text to milliseconds parser.
// Usage:
//   Input channel (in_valid/in_ready) carries one text byte per transfer in
//   char_code; is_last marks the final byte of a text. Tokens such as "18d",
//   "-4h", " 12s" or "78ms" are summed; an unmarked number counts as ms.
//   Output channel (out_valid/out_ready) gives one total_ms per text, the
//   two's complement sum in milliseconds, after the transfer of the last byte.
// Throughput: one byte per cycle. The parse state (phase, magnitude, sign)
//   closes its loop within the parse stage; the unit scaling multiply and the
//   running sum sit in stages after it and do not feed back.
// Path: the last byte passes the input register and the parse, scale and
//   merge registers; the result register then takes the total and out_valid.
// Stall: the result register holds a finished total while the receiver
//   keeps out_ready low; bytes of the next text keep flowing and are summed.
//   Only a second finished total reaching the accumulate stage then halts
//   the pipeline, which drops in_ready until the waiting total transfers.
// Reset: arst_n clears all valid flags, the parse state and the running sum;
//   the first byte after reset starts a new text.
`default_nettype none

module duration_text_to_milliseconds (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         char_code,
	input  wire logic               is_last,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [63:0]      total_ms
);

	logic               adv;

	logic               v_s1;
	logic [7:0]         char_s1;
	logic               last_s1;

	dttm_pkg::tok_out_t tok;
	logic               v_s2;
	logic               last_s2;
	dttm_pkg::tok_out_t tok_s2;

	logic [63:0]        prod;
	logic               v_s3;
	logic               last_s3;
	logic [63:0]        prod_s3;
	logic [63:0]        valb_s3;

	logic               v_s4;
	logic               last_s4;
	logic [63:0]        addend_s4;

	logic [63:0]        sum;
	logic [63:0]        total_q;
	logic [63:0]        total_ms_q;
	logic               out_valid_q;

	// Halt everything only when a finished total cannot enter the result register
	assign adv      = !(v_s4 && last_s4 && out_valid_q && !out_ready);
	assign in_ready = adv;

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	// Stage 2: parse one byte, emit finished token values
	dttm_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv && v_s1),
		.ch     (char_s1),
		.last   (last_s1),
		.tok    (tok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			tok_s2  <= (v_s1) ? tok : '0;
		end
	end

	// Stage 3: scale by the unit, wrapping at 64 bits
	always_comb begin
		case (tok_s2.factor)
			dttm_pkg::FAC_MS:   prod = tok_s2.val_a;
			dttm_pkg::FAC_SEC:  prod = tok_s2.val_a * dttm_pkg::MS_PER_SEC;
			dttm_pkg::FAC_MIN:  prod = tok_s2.val_a * dttm_pkg::MS_PER_MIN;
			dttm_pkg::FAC_HOUR: prod = tok_s2.val_a * dttm_pkg::MS_PER_HOUR;
			dttm_pkg::FAC_DAY:  prod = tok_s2.val_a * dttm_pkg::MS_PER_DAY;
			default:            prod = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3 <= last_s2;
			prod_s3 <= prod;
			valb_s3 <= tok_s2.val_b;
		end
	end

	// Stage 4: merge the two contributions of a byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s4   <= last_s3;
			addend_s4 <= prod_s3 + valb_s3;
		end
	end

	// Accumulate; on the last byte hand the total to the result register and restart
	assign sum = total_q + addend_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && v_s4) begin
				total_q <= last_s4 ? 64'd0 : sum;
			end
			if (adv && v_s4 && last_s4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4 && last_s4) begin
			total_ms_q <= sum;
		end
	end

	assign out_valid = out_valid_q;
	assign total_ms  = total_ms_q;

endmodule

`default_nettype wire

/* design/dttm_parse.sv */
// Per-character token parser: phase, magnitude and sign state plus token emission.
`default_nettype none

module dttm_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        ch,
	input  wire logic              last,
	output dttm_pkg::tok_out_t     tok
);

	dttm_pkg::phase_t  phase_q;
	logic [63:0]       mag_q;
	logic              neg_q;

	dttm_pkg::phase_t  nph;
	logic [63:0]       nmag;
	logic              nneg;

	dttm_pkg::phase_t  st_ph;
	logic [63:0]       st_mag;
	logic              st_neg;

	logic [7:0]        lc;
	logic              is_ws, is_sign, is_dig, is_m, is_s, is_h, is_d;
	logic [3:0]        dval;
	logic [63:0]       base_mag, thr, cap, dig_mag, old_val, new_val;
	logic              base_neg;
	logic              emit;
	dttm_pkg::factor_t fac;

	always_comb begin
		lc = (ch >= dttm_pkg::CH_UP_A && ch <= dttm_pkg::CH_UP_Z) ?
			ch + dttm_pkg::CH_CASE : ch;
		is_ws   = (ch == dttm_pkg::CH_SPACE) ||
			(ch >= dttm_pkg::CH_TAB && ch <= dttm_pkg::CH_CR);
		is_sign = (ch == dttm_pkg::CH_PLUS) || (ch == dttm_pkg::CH_MINUS);
		is_dig  = (ch >= dttm_pkg::CH_ZERO) && (ch <= dttm_pkg::CH_NINE);
		is_m    = (lc == dttm_pkg::CH_LO_M);
		is_s    = (lc == dttm_pkg::CH_LO_S);
		is_h    = (lc == dttm_pkg::CH_LO_H);
		is_d    = (lc == dttm_pkg::CH_LO_D);
		dval    = ch[3:0];

		// Digit accumulation with saturation at the signed limits
		base_mag = (phase_q == dttm_pkg::PH_DIG) ? mag_q : 64'd0;
		base_neg = neg_q && (phase_q == dttm_pkg::PH_SIGN || phase_q == dttm_pkg::PH_DIG);
		thr      = dttm_pkg::MAG_THR - {63'd0, (dval > (base_neg ?
			dttm_pkg::NEG_LAST_DIGIT : dttm_pkg::POS_LAST_DIGIT))};
		cap      = base_neg ? dttm_pkg::NEG_CAP : dttm_pkg::POS_CAP;
		dig_mag  = (base_mag > thr) ? cap :
			(base_mag << 3) + (base_mag << 1) + {60'd0, dval};

		old_val = neg_q ? (64'd0 - mag_q) : mag_q;

		// Fresh token start for this character
		st_mag = 64'd0;
		st_neg = 1'b0;
		if (is_ws) begin
			st_ph = dttm_pkg::PH_WS;
		end else if (is_sign) begin
			st_ph  = dttm_pkg::PH_SIGN;
			st_neg = (ch == dttm_pkg::CH_MINUS);
		end else if (is_dig) begin
			st_ph  = dttm_pkg::PH_DIG;
			st_mag = {60'd0, dval};
		end else if (is_m) begin
			st_ph = dttm_pkg::PH_PENDM;
		end else if (is_s || is_h || is_d) begin
			st_ph = dttm_pkg::PH_START;
		end else begin
			st_ph = dttm_pkg::PH_STOP;
		end

		nph  = phase_q;
		nmag = mag_q;
		nneg = neg_q;
		emit = 1'b0;
		fac  = dttm_pkg::FAC_MS;
		case (phase_q)
			dttm_pkg::PH_START: begin
				nph  = st_ph;
				nmag = st_mag;
				nneg = st_neg;
			end
			dttm_pkg::PH_WS: begin
				if (is_ws) begin
					nph = dttm_pkg::PH_WS;
				end else if (is_sign) begin
					nph  = dttm_pkg::PH_SIGN;
					nneg = (ch == dttm_pkg::CH_MINUS);
				end else if (is_dig) begin
					nph  = dttm_pkg::PH_DIG;
					nmag = dig_mag;
				end else begin
					nph = dttm_pkg::PH_STOP;
				end
			end
			dttm_pkg::PH_SIGN: begin
				if (is_dig) begin
					nph  = dttm_pkg::PH_DIG;
					nmag = dig_mag;
				end else begin
					nph = dttm_pkg::PH_STOP;
				end
			end
			dttm_pkg::PH_DIG: begin
				if (is_dig) begin
					nmag = dig_mag;
				end else if (is_m) begin
					nph = dttm_pkg::PH_PENDM;
				end else if (is_s || is_h || is_d) begin
					emit = 1'b1;
					fac  = is_s ? dttm_pkg::FAC_SEC :
						(is_h ? dttm_pkg::FAC_HOUR : dttm_pkg::FAC_DAY);
					nph  = dttm_pkg::PH_START;
					nmag = 64'd0;
					nneg = 1'b0;
				end else begin
					emit = 1'b1;
					nph  = st_ph;
					nmag = st_mag;
					nneg = st_neg;
				end
			end
			dttm_pkg::PH_PENDM: begin
				emit = 1'b1;
				if (is_s) begin
					nph  = dttm_pkg::PH_START;
					nmag = 64'd0;
					nneg = 1'b0;
				end else begin
					fac  = dttm_pkg::FAC_MIN;
					nph  = st_ph;
					nmag = st_mag;
					nneg = st_neg;
				end
			end
			default: begin
				nph = dttm_pkg::PH_STOP;
			end
		endcase

		new_val = nneg ? (64'd0 - nmag) : nmag;

		// Token left open at text end: digits count as ms, a pending 'm' as minutes.
		// With an emission already present the open token is at most one digit.
		tok.factor = fac;
		tok.val_a  = emit ? old_val : 64'd0;
		tok.val_b  = 64'd0;
		if (last) begin
			if (emit) begin
				if (nph == dttm_pkg::PH_DIG) begin
					tok.val_b = new_val;
				end
			end else if (nph == dttm_pkg::PH_DIG) begin
				tok.factor = dttm_pkg::FAC_MS;
				tok.val_a  = new_val;
			end else if (nph == dttm_pkg::PH_PENDM) begin
				tok.factor = dttm_pkg::FAC_MIN;
				tok.val_a  = new_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dttm_pkg::PH_START;
			mag_q   <= 64'd0;
			neg_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q <= dttm_pkg::PH_START;
				mag_q   <= 64'd0;
				neg_q   <= 1'b0;
			end else begin
				phase_q <= nph;
				mag_q   <= nmag;
				neg_q   <= nneg;
			end
		end
	end

endmodule

`default_nettype wire

/* design/dttm_props.sv */
// Port-level checks for the duration text to milliseconds parser, bound to the top level.
`default_nettype none

module dttm_props (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [7:0]        char_code,
	input wire logic              is_last,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic signed [63:0] total_ms
);

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_ms))
		else $error("result changed or dropped while stalled");

	// Drop in_ready only behind a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// With the pipeline flowing, no result appears without a matching last byte having entered earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(in_ready, 1) && $past(in_ready, 2) && $past(in_ready, 3) &&
		$past(in_ready, 4) && !$past(in_valid && in_ready && is_last, 4)
		|=> !out_valid)
		else $error("result without a matching last byte");

	// Feed char_code into a trivial check so every port is observed
	a_char_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !$isunknown(char_code))
		else $error("unknown byte transferred");

endmodule

bind duration_text_to_milliseconds dttm_props u_dttm_props (.*);

`default_nettype wire

/* tb/duration_total_checker.sv */
// Checker that predicts the millisecond total of each text and compares it with the output.
`default_nettype none

module duration_total_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [7:0]         char_code,
	input  wire logic               is_last,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [63:0] total_ms,
	output int                      due,
	output int                      fails
);
	timeunit 1ns;
	timeprecision 1ps;

	dttm_pkg::phase_t phase;
	logic [63:0] mag;
	logic        neg;
	logic [63:0] total;
	logic [63:0] totals_due[$];
	int          errs;

	function automatic logic is_space(logic [7:0] c);
		return c == dttm_pkg::CH_SPACE || (c >= dttm_pkg::CH_TAB && c <= dttm_pkg::CH_CR);
	endfunction

	function automatic logic is_num(logic [7:0] c);
		return c >= dttm_pkg::CH_ZERO && c <= dttm_pkg::CH_NINE;
	endfunction

	function automatic logic [7:0] fold_case(logic [7:0] c);
		return (c >= dttm_pkg::CH_UP_A && c <= dttm_pkg::CH_UP_Z) ? c + dttm_pkg::CH_CASE : c;
	endfunction

	task fold_token(input logic [63:0] scale);
		logic [63:0] v;
		v = neg ? -mag : mag;
		total = total + v * scale;
		mag = '0;
		neg = 1'b0;
	endtask

	// saturate at 2^63-1, or 2^63 for a negative token
	task accumulate_digit(input logic [7:0] c);
		logic [63:0] cap;
		logic [63:0] d;
		cap = neg ? dttm_pkg::NEG_CAP : dttm_pkg::POS_CAP;
		d = 64'(c - dttm_pkg::CH_ZERO);
		if (mag > (cap - d) / 64'd10)
			mag = cap;
		else
			mag = mag * 64'd10 + d;
		phase = dttm_pkg::PH_DIG;
	endtask

	task open_token(input logic [7:0] c);
		logic [7:0] l;
		l = fold_case(c);
		mag = '0;
		neg = 1'b0;
		if (is_space(c)) begin
			phase = dttm_pkg::PH_WS;
		end else if (c == dttm_pkg::CH_PLUS || c == dttm_pkg::CH_MINUS) begin
			neg = (c == dttm_pkg::CH_MINUS);
			phase = dttm_pkg::PH_SIGN;
		end else if (is_num(c)) begin
			accumulate_digit(c);
		end else if (l == dttm_pkg::CH_LO_M) begin
			phase = dttm_pkg::PH_PENDM;
		end else if (l == dttm_pkg::CH_LO_S || l == dttm_pkg::CH_LO_H ||
				l == dttm_pkg::CH_LO_D) begin
			phase = dttm_pkg::PH_START;
		end else begin
			phase = dttm_pkg::PH_STOP;
		end
	endtask

	task clear_text();
		phase = dttm_pkg::PH_START;
		mag = '0;
		neg = 1'b0;
		total = '0;
	endtask

	task parse_char(input logic [7:0] c, input logic last);
		logic [7:0] l;
		l = fold_case(c);
		case (phase)
			dttm_pkg::PH_START: begin
				open_token(c);
			end
			dttm_pkg::PH_WS: begin
				if (is_space(c)) begin
					phase = dttm_pkg::PH_WS;
				end else if (c == dttm_pkg::CH_PLUS || c == dttm_pkg::CH_MINUS) begin
					neg = (c == dttm_pkg::CH_MINUS);
					phase = dttm_pkg::PH_SIGN;
				end else if (is_num(c)) begin
					accumulate_digit(c);
				end else begin
					phase = dttm_pkg::PH_STOP;
				end
			end
			dttm_pkg::PH_SIGN: begin
				if (is_num(c))
					accumulate_digit(c);
				else
					phase = dttm_pkg::PH_STOP;
			end
			dttm_pkg::PH_DIG: begin
				if (is_num(c)) begin
					accumulate_digit(c);
				end else if (l == dttm_pkg::CH_LO_M) begin
					phase = dttm_pkg::PH_PENDM;
				end else if (l == dttm_pkg::CH_LO_S) begin
					fold_token(dttm_pkg::MS_PER_SEC);
					phase = dttm_pkg::PH_START;
				end else if (l == dttm_pkg::CH_LO_H) begin
					fold_token(dttm_pkg::MS_PER_HOUR);
					phase = dttm_pkg::PH_START;
				end else if (l == dttm_pkg::CH_LO_D) begin
					fold_token(dttm_pkg::MS_PER_DAY);
					phase = dttm_pkg::PH_START;
				end else begin
					fold_token(64'd1);
					open_token(c);
				end
			end
			dttm_pkg::PH_PENDM: begin
				if (l == dttm_pkg::CH_LO_S) begin
					fold_token(64'd1);
					phase = dttm_pkg::PH_START;
				end else begin
					fold_token(dttm_pkg::MS_PER_MIN);
					open_token(c);
				end
			end
			default: begin
				phase = dttm_pkg::PH_STOP;
			end
		endcase
		if (last) begin
			if (phase == dttm_pkg::PH_DIG)
				fold_token(64'd1);
			else if (phase == dttm_pkg::PH_PENDM)
				fold_token(dttm_pkg::MS_PER_MIN);
			totals_due.push_back(total);
			clear_text();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			clear_text();
			totals_due.delete();
			errs = 0;
			due <= 0;
			fails <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (totals_due.size() == 0) begin
					$error("total_ms: no total expected, actual %0d", total_ms);
					errs++;
				end else begin
					want = totals_due.pop_front();
					if (want !== total_ms) begin
						$error("total_ms: expected %0d, actual %0d", $signed(want), total_ms);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				parse_char(char_code, is_last);
			due <= totals_due.size();
			fails <= errs;
		end
	end

endmodule

`default_nettype wire

/* tb/tb_duration_text_to_milliseconds.sv */
// Testbench top: drives duration texts into the parser and gives the verdict.
`default_nettype none

module tb_duration_text_to_milliseconds;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTE_GOAL = 1000;
	localparam logic [7:0] CH_NUL = 8'h00;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         char_code;
	logic               is_last;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] total_ms;
	int                 due;
	int                 fails;

	int                 cycles = 0;
	int                 bytes_sent = 0;
	bit                 calm = 1'b0;
	logic [7:0]         text[$];

	duration_text_to_milliseconds uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.total_ms(total_ms)
	);

	duration_total_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.total_ms(total_ms),
		.due(due),
		.fails(fails)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Abort a hung run; the limit covers the slowest legal mix of gaps and stalls.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly no gap or a short one, now and then a long one; none during a calm stretch.
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one byte and hold it until the transfer happens. Valid is only
	// lowered when a gap is taken, so back-to-back bytes keep it high.
	task send_byte(input logic [7:0] c, input logic last);
		int g;
		g = idle_cycles();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		is_last <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	// Send the staged text, marking its final byte, then clear the stage.
	task send_text();
		for (int i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
		text.delete();
	endtask

	task add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endtask

	// Hold off the input until every predicted total has been transferred.
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due != 0) @(posedge clk);
	endtask

	task add_letter(input logic [7:0] c);
		text.push_back($urandom_range(0, 1) ? c - dttm_pkg::CH_CASE : c);
	endtask

	// Stage one random text. Most texts are chains of well-formed tokens with
	// random whitespace, signs, digit counts and units; some carry stray
	// bytes, and a few are pure noise across the whole byte range.
	task build_text();
		int n_tok;
		int n_dig;
		int r;
		int k;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n_tok = $urandom_range(1, 4);
		repeat (n_tok) begin
			// leading whitespace drawn from the full set
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 2)) begin
					k = $urandom_range(0, 5);
					text.push_back(k == 5 ? dttm_pkg::CH_SPACE : dttm_pkg::CH_TAB + 8'(k));
				end
			end
			r = $urandom_range(0, 5);
			if (r == 0)
				text.push_back(dttm_pkg::CH_PLUS);
			else if (r == 1)
				text.push_back(dttm_pkg::CH_MINUS);
			// digit count: mostly short, some long enough to saturate,
			// some right at the saturation edge
			r = $urandom_range(0, 99);
			if (r < 5) begin
				n_dig = 0;
			end else if (r < 70) begin
				n_dig = $urandom_range(1, 4);
			end else if (r < 85) begin
				n_dig = $urandom_range(5, 12);
			end else if (r < 93) begin
				n_dig = $urandom_range(17, 22);
			end else begin
				n_dig = 0;
				repeat ($urandom_range(0, 2)) text.push_back(dttm_pkg::CH_ZERO);
				add_str("922337203685477580");
				text.push_back(dttm_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
			end
			repeat (n_dig) text.push_back(dttm_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
			case ($urandom_range(0, 5))
				0: ;
				1: begin
					add_letter(dttm_pkg::CH_LO_M);
					add_letter(dttm_pkg::CH_LO_S);
				end
				2: add_letter(dttm_pkg::CH_LO_M);
				3: add_letter(dttm_pkg::CH_LO_S);
				4: add_letter(dttm_pkg::CH_LO_H);
				default: add_letter(dttm_pkg::CH_LO_D);
			endcase
			if ($urandom_range(0, 19) == 0)
				text.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver: stall for random stretches, then accept for a short random stretch.
	initial begin
		int s;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			s = idle_cycles();
			if (s > 0) begin
				out_ready <= 1'b0;
				repeat (s) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		in_valid = 1'b0;
		char_code = '0;
		is_last = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		// release reset; the flops still see it asserted at this edge
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts. A final 'm' means minutes; "Ms" in upper case.
		add_str("1m");
		send_text();
		add_str("3Ms");
		send_text();
		// hours, then a negative token in days
		add_str("4h-2D");
		send_text();
		// whitespace and plus sign; an unknown byte where a token starts stops parsing
		add_str(" +7sx");
		send_text();
		// a unit with no digits counts as zero
		add_str("s9");
		send_text();
		// NUL stops parsing; the all-ones byte after it is ignored
		text.push_back(CH_NUL);
		text.push_back(8'hFF);
		send_text();
		// a stray byte after digits ends the token as ms, then stops
		add_str("8,9");
		send_text();
		// a sign with no digits stops parsing
		add_str("-");
		send_text();
		drain();

		// Random texts until the byte goal is met; flip calm stretches now and then.
		while (bytes_sent < BYTE_GOAL) begin
			if ($urandom_range(0, 9) == 0)
				calm = !calm;
			build_text();
			send_text();
			if ($urandom_range(0, 29) == 0)
				drain();
		end

		// Wait out the last totals, then keep watching for stray output before the verdict.
		drain();
		repeat (12) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
